// ===== src/ttt_pkg.sv =====
// Shared types, sizes and codes for the tick task timer table.
// No dependencies; every other file imports this package.
package ttt_pkg;

   localparam int TBL_SIZE = 16;
   localparam int IDX_W    = 4;
   localparam int CNT_W    = 5;
   localparam int KEY_W    = 16;
   localparam int TIME_W   = 32;

   // request modes
   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_CREATE = 3'd1;
   localparam logic [2:0] MODE_DELETE = 3'd2;
   localparam logic [2:0] MODE_SETDLY = 3'd3;
   localparam logic [2:0] MODE_SETRLD = 3'd4;
   localparam logic [2:0] MODE_DISP   = 3'd5;

   // result status codes
   localparam logic [3:0] ST_CREATED  = 4'd0;
   localparam logic [3:0] ST_DELETED  = 4'd1;
   localparam logic [3:0] ST_UPDATED  = 4'd2;
   localparam logic [3:0] ST_NOTFOUND = 4'd3;
   localparam logic [3:0] ST_FULL     = 4'd4;
   localparam logic [3:0] ST_EMPTYKEY = 4'd5;
   localparam logic [3:0] ST_DISP     = 4'd6;
   localparam logic [3:0] ST_NONE     = 4'd7;
   localparam logic [3:0] ST_TICKDONE = 4'd8;

   typedef struct packed {
      logic [2:0]        mode;
      logic [KEY_W-1:0]  task_key;
      logic              one_shot;
      logic [TIME_W-1:0] delay_value;
      logic [TIME_W-1:0] reload_value;
   } req_type;

   typedef struct packed {
      logic [3:0]       status;
      logic [KEY_W-1:0] ready_key;
      logic             last;
      logic             queue_overflow;
      logic [CNT_W-1:0] task_count;
   } rsp_type;

endpackage

// ===== src/ttt_front.sv =====
// Front end: accepts requests, drops unused modes, holds a two-entry queue.
// Depends on ttt_pkg.
module ttt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ttt_pkg::req_type in_req,
   output logic             full,
   output logic             op_valid,
   output ttt_pkg::req_type op_req,
   input  logic             op_take
);
   import ttt_pkg::*;

   req_type    slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   // keep only modes that produce work
   assign push = in_valid && (in_req.mode <= MODE_DISP);

   assign full     = (cnt_ff == 2'd2);
   assign op_valid = (cnt_ff != 2'd0);
   assign op_req   = slot_ff[rd_ff];

   // advance pointers and fill
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ op_take;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, op_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= in_req;
      end
   end

endmodule

// ===== src/ttt_exec.sv =====
// Back end: task table, ready queue and the sequencer that walks them.
// Depends on ttt_pkg.
module ttt_exec (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   input  ttt_pkg::req_type op_req,
   output logic             op_take,
   output logic             rsp_valid,
   output ttt_pkg::rsp_type rsp_data
);
   import ttt_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_TICK    = 4'd1;
   localparam logic [3:0] S_FIND    = 4'd2;
   localparam logic [3:0] S_RMFIND  = 4'd3;
   localparam logic [3:0] S_RMSHIFT = 4'd4;
   localparam logic [3:0] S_MOVE    = 4'd5;
   localparam logic [3:0] S_DPOP    = 4'd6;
   localparam logic [3:0] S_DEMIT   = 4'd7;

   logic [KEY_W-1:0]  keys_ff [TBL_SIZE], keys_in [TBL_SIZE];
   logic              shot_ff [TBL_SIZE], shot_in [TBL_SIZE];
   logic [TIME_W-1:0] cd_ff   [TBL_SIZE], cd_in   [TBL_SIZE];
   logic [TIME_W-1:0] rl_ff   [TBL_SIZE], rl_in   [TBL_SIZE];
   logic [KEY_W-1:0]  fifo_ff [TBL_SIZE], fifo_in [TBL_SIZE];
   logic [KEY_W-1:0]  obuf_ff [TBL_SIZE], obuf_in [TBL_SIZE];

   logic [CNT_W-1:0]  total_ff, total_in, fill_ff, fill_in;
   logic [IDX_W-1:0]  head_ff, head_in, slot_ff, slot_in;
   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in, ocnt_ff, ocnt_in, optr_ff, optr_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [2:0]        mode_ff, mode_in;
   logic              dsp_ff, dsp_in, ovf_ff, ovf_in;
   logic              rv_ff, rv_in;
   rsp_type           rsp_ff, rsp_in;

   // hold the new values of a pending update
   logic [TIME_W-1:0] op_dly_ff, op_rld_ff;

   logic [IDX_W-1:0]  ix, fpos, fnext, lastslot;
   logic [TIME_W-1:0] dec;
   logic              emit_last;

   assign ix        = idx_ff[IDX_W-1:0];
   assign fpos      = head_ff + ix;
   assign fnext     = fpos + 1'b1;
   assign lastslot  = total_ff[IDX_W-1:0] - 1'b1;
   assign dec       = (cd_ff[ix] != '0) ? cd_ff[ix] - 1'b1 : '0;
   assign emit_last = (optr_ff + 1'b1 == ocnt_ff);

   assign op_take   = (state_ff == S_IDLE) && op_valid;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   // sequence one request at a time over the table and queue
   always_comb begin
      keys_in  = keys_ff;
      shot_in  = shot_ff;
      cd_in    = cd_ff;
      rl_in    = rl_ff;
      fifo_in  = fifo_ff;
      obuf_in  = obuf_ff;
      total_in = total_ff;
      fill_in  = fill_ff;
      head_in  = head_ff;
      slot_in  = slot_ff;
      state_in = state_ff;
      idx_in   = idx_ff;
      ocnt_in  = ocnt_ff;
      optr_in  = optr_ff;
      key_in   = key_ff;
      mode_in  = mode_ff;
      dsp_in   = dsp_ff;
      ovf_in   = ovf_ff;
      rv_in    = 1'b0;
      rsp_in   = '0;
      rsp_in.last = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               key_in  = op_req.task_key;
               mode_in = op_req.mode;
               idx_in  = '0;
               dsp_in  = 1'b0;
               ovf_in  = 1'b0;
               case (op_req.mode)
                  MODE_TICK: state_in = S_TICK;
                  MODE_CREATE: begin
                     rv_in = 1'b1;
                     if (total_ff == CNT_W'(TBL_SIZE)) begin
                        rsp_in.status = ST_FULL;
                     end else if (op_req.task_key == '0) begin
                        rsp_in.status = ST_EMPTYKEY;
                     end else begin
                        keys_in[total_ff[IDX_W-1:0]] = op_req.task_key;
                        shot_in[total_ff[IDX_W-1:0]] = op_req.one_shot;
                        cd_in[total_ff[IDX_W-1:0]]   = op_req.delay_value;
                        rl_in[total_ff[IDX_W-1:0]]   = op_req.reload_value;
                        total_in = total_ff + 1'b1;
                        rsp_in.status = ST_CREATED;
                     end
                  end
                  MODE_DISP: begin
                     dsp_in  = 1'b1;
                     ocnt_in = '0;
                     if (fill_ff == '0) begin
                        rv_in = 1'b1;
                        rsp_in.status = ST_NONE;
                     end else begin
                        state_in = S_DPOP;
                     end
                  end
                  default: begin
                     if (op_req.task_key == '0) begin
                        rv_in = 1'b1;
                        rsp_in.status = ST_EMPTYKEY;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
               endcase
            end
         end
         S_TICK: begin
            // count down one entry, reload and queue on expiry
            if (idx_ff == total_ff) begin
               rv_in = 1'b1;
               rsp_in.status = ST_TICKDONE;
               rsp_in.queue_overflow = ovf_ff;
               state_in = S_IDLE;
            end else begin
               if (dec == '0) begin
                  cd_in[ix] = rl_ff[ix];
                  if (fill_ff == CNT_W'(TBL_SIZE)) begin
                     ovf_in = 1'b1;
                  end else begin
                     fifo_in[head_ff + fill_ff[IDX_W-1:0]] = keys_ff[ix];
                     fill_in = fill_ff + 1'b1;
                  end
               end else begin
                  cd_in[ix] = dec;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FIND: begin
            // search the lowest slot holding the key
            if (idx_ff == total_ff) begin
               if (dsp_ff) begin
                  state_in = S_DPOP;
               end else begin
                  rv_in = 1'b1;
                  rsp_in.status = ST_NOTFOUND;
                  state_in = S_IDLE;
               end
            end else if (keys_ff[ix] == key_ff) begin
               slot_in = ix;
               idx_in  = '0;
               if (dsp_ff) begin
                  state_in = shot_ff[ix] ? S_RMFIND : S_DPOP;
               end else if (mode_ff == MODE_DELETE) begin
                  state_in = S_RMFIND;
               end else begin
                  rv_in = 1'b1;
                  rsp_in.status = ST_UPDATED;
                  state_in = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_RMFIND: begin
            // locate the first queued copy of the key
            if (idx_ff == fill_ff) begin
               state_in = S_MOVE;
            end else if (fifo_ff[fpos] == key_ff) begin
               state_in = S_RMSHIFT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_RMSHIFT: begin
            // close the gap one slot a cycle
            if (idx_ff + 1'b1 < fill_ff) begin
               fifo_in[fpos] = fifo_ff[fnext];
               idx_in = idx_ff + 1'b1;
            end else begin
               fill_in  = fill_ff - 1'b1;
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            // fill the freed slot with the last entry
            keys_in[slot_ff] = keys_ff[lastslot];
            shot_in[slot_ff] = shot_ff[lastslot];
            cd_in[slot_ff]   = cd_ff[lastslot];
            rl_in[slot_ff]   = rl_ff[lastslot];
            total_in = total_ff - 1'b1;
            if (dsp_ff) begin
               state_in = S_DPOP;
            end else begin
               rv_in = 1'b1;
               rsp_in.status = ST_DELETED;
               state_in = S_IDLE;
            end
         end
         S_DPOP: begin
            // pop the next ready key, or start emitting
            if (fill_ff == '0) begin
               optr_in  = '0;
               state_in = S_DEMIT;
            end else begin
               key_in = fifo_ff[head_ff];
               obuf_in[ocnt_ff[IDX_W-1:0]] = fifo_ff[head_ff];
               ocnt_in = ocnt_ff + 1'b1;
               head_in = head_ff + 1'b1;
               fill_in = fill_ff - 1'b1;
               idx_in  = '0;
               state_in = S_FIND;
            end
         end
         S_DEMIT: begin
            rv_in = 1'b1;
            rsp_in.status    = ST_DISP;
            rsp_in.ready_key = obuf_ff[optr_ff[IDX_W-1:0]];
            rsp_in.last      = emit_last;
            optr_in = optr_ff + 1'b1;
            if (emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // apply the new delay on a set-delay hit, or the new reload on a set-reload hit
      if (state_ff == S_FIND && !dsp_ff && idx_ff != total_ff && keys_ff[ix] == key_ff) begin
         if (mode_ff == MODE_SETDLY) begin
            cd_in[ix] = op_dly_ff;
         end else if (mode_ff == MODE_SETRLD) begin
            rl_in[ix] = op_rld_ff;
         end
      end
      rsp_in.task_count = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         fill_ff  <= '0;
         head_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         fill_ff  <= fill_in;
         head_ff  <= head_in;
         rv_ff    <= rv_in;
      end
      keys_ff <= keys_in;
      shot_ff <= shot_in;
      cd_ff   <= cd_in;
      rl_ff   <= rl_in;
      fifo_ff <= fifo_in;
      obuf_ff <= obuf_in;
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      ocnt_ff <= ocnt_in;
      optr_ff <= optr_in;
      key_ff  <= key_in;
      mode_ff <= mode_in;
      dsp_ff  <= dsp_in;
      ovf_ff  <= ovf_in;
      rsp_ff  <= rsp_in;
      if (op_take) begin
         op_dly_ff <= op_req.delay_value;
         op_rld_ff <= op_req.reload_value;
      end
   end

endmodule

// ===== src/tick_task_timer_table_top.sv =====
// Top level of the tick task timer table: front queue plus sequencer.
// Depends on ttt_pkg, ttt_front and ttt_exec.
//
// Usage: drive req_data and raise start; the request is taken at an edge
// where start is high and busy is low. Modes 6 and 7 are taken and ignored.
// Results appear on rsp_data for one cycle, marked by rsp_valid; the
// receiver cannot stall them. The final result of a request has last set.
// A two-entry request queue sits in front of the sequencer, so busy rises
// only when both entries wait.
// With the sequencer idle, create answers and empty-key or full answers are
// given directly; set delay or reload and tick walk the table; delete walks
// the table, then the ready queue, then moves the last entry into the freed
// slot; dispatch walks the table (and the queue for a one-shot key) for
// every popped key and then emits one result a cycle. The sequencer works
// on one request at a time and takes the next queued one once it is idle.
// Reset (synchronous, active high) empties the table and the ready queue.
module tick_task_timer_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ttt_pkg::req_type req_data,
   output logic             rsp_valid,
   output ttt_pkg::rsp_type rsp_data
);
   import ttt_pkg::*;

   logic    op_valid, op_take;
   req_type op_req;

   ttt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_req   (req_data),
      .full     (busy),
      .op_valid (op_valid),
      .op_req   (op_req),
      .op_take  (op_take)
   );

   ttt_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op_req    (op_req),
      .op_take   (op_take),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
